// ===== rtl/bfc_pkg.sv =====
// Shared types and constants of the box frustum cull test.
// Used by bfc_cell, bfc_ctrl, box_frustum_cull_test, bfc_verdict_checker and tb; depends on nothing.
`timescale 1ns / 1ps

package bfc_pkg;

   // Plane counts and index widths
   localparam int NUM_CLIP_PLANES = 6;
   localparam int VIEW_PLANES     = 6;
   localparam int NUM_PLANES      = VIEW_PLANES + NUM_CLIP_PLANES;
   localparam int PLANE_W         = $clog2(NUM_PLANES);
   localparam int CLIP_W          = 3;
   localparam int SLOT_W          = 3;
   localparam int MAT_ROWS        = 4;
   localparam int NUM_CELLS       = 4;

   // Datapath widths
   localparam int COEF_W      = 32;
   localparam int OPA_W       = 33;
   localparam int PROD_W      = OPA_W + COEF_W;
   localparam int SUM_W       = 68;
   localparam int E_W         = 50;
   localparam int SLICE_SPLIT = 25;
   localparam int SLICE_W     = SLICE_SPLIT + 1;
   localparam int TOT_W       = 86;
   localparam int FRAC_W      = 16;

   localparam logic signed [COEF_W-1:0] ONE_Q = 32'sd65536;

   // Request function codes
   localparam logic [1:0] FUNC_LOAD_ROW   = 2'd0;
   localparam logic [1:0] FUNC_LOAD_PLANE = 2'd1;
   localparam logic [1:0] FUNC_TEST       = 2'd2;

   // Verdict codes
   localparam logic [1:0] VERDICT_INSIDE  = 2'd0;
   localparam logic [1:0] VERDICT_PARTIAL = 2'd1;
   localparam logic [1:0] VERDICT_REJECT  = 2'd2;

   // Store write controls from the sequencer
   typedef struct packed {
      logic mat_we;
      logic pln_we;
      logic box_we;
   } we_type;

   // Per-cell write port
   typedef struct packed {
      logic              mat_we;
      logic              pln_we;
      logic              box_we;
      logic [SLOT_W-1:0] slot;
      logic [COEF_W-1:0] coef;
      logic [COEF_W-1:0] lo;
      logic [COEF_W-1:0] hi;
   } wr_type;

   // Packet handed from cell to cell
   typedef struct packed {
      logic                               valid;
      logic                               corner;
      logic [1:0]                         row;
      logic [PLANE_W-1:0]                 plane;
      logic                               far;
      logic                               hi_slice;
      logic [NUM_CELLS-1:0]               pos;
      logic [NUM_CELLS-1:0][SLICE_W-1:0]  slice;
      logic [SUM_W-1:0]                   sum;
   } pkt_type;

endpackage

// ===== rtl/bfc_cell.sv =====
// One multiply-accumulate cell of the cull chain: holds one matrix column,
// one clip plane column and one box axis. Depends on bfc_pkg.
`timescale 1ns / 1ps

module bfc_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       cell_idx,
   input  bfc_pkg::wr_type  wr,
   input  bfc_pkg::pkt_type pkt_in,
   output bfc_pkg::pkt_type pkt_out
);

   logic [bfc_pkg::COEF_W-1:0] mat_ff [bfc_pkg::MAT_ROWS];
   logic [bfc_pkg::COEF_W-1:0] pln_ff [bfc_pkg::NUM_CLIP_PLANES];
   logic [bfc_pkg::COEF_W-1:0] lo_ff;
   logic [bfc_pkg::COEF_W-1:0] hi_ff;
   bfc_pkg::pkt_type           pkt_ff;
   bfc_pkg::pkt_type           pkt_in_mod;

   logic [1:0]                        view_col;
   logic                              view_plus;
   logic [bfc_pkg::COEF_W-1:0]        view_coef;
   logic [bfc_pkg::CLIP_W-1:0]        clip_idx;
   logic [bfc_pkg::COEF_W-1:0]        plane_coef;
   logic [bfc_pkg::SLICE_W-1:0]       my_slice;
   logic signed [bfc_pkg::OPA_W-1:0]  a_op;
   logic signed [bfc_pkg::COEF_W-1:0] b_op;
   logic signed [bfc_pkg::PROD_W-1:0] prod;

   // Store writes
   always_ff @(posedge clock) begin
      if (wr.mat_we) begin
         mat_ff[wr.slot[1:0]] <= wr.coef;
      end
      if (wr.pln_we) begin
         pln_ff[wr.slot] <= wr.coef;
      end
      if (wr.box_we) begin
         lo_ff <= wr.lo;
         hi_ff <= wr.hi;
      end
   end

   // View plane weight: column 3 plus or minus one other column, in Q16.16
   always_comb begin
      view_col  = pkt_in.plane[2:1];
      view_plus = ~pkt_in.plane[0];
      if (cell_idx == 2'd3) begin
         view_coef = bfc_pkg::ONE_Q;
      end else if (cell_idx == view_col) begin
         view_coef = view_plus ? bfc_pkg::ONE_Q : -bfc_pkg::ONE_Q;
      end else begin
         view_coef = '0;
      end
   end

   assign clip_idx   = bfc_pkg::CLIP_W'(pkt_in.plane -
                                        bfc_pkg::PLANE_W'(bfc_pkg::VIEW_PLANES));
   assign plane_coef = (pkt_in.plane < bfc_pkg::PLANE_W'(bfc_pkg::VIEW_PLANES)) ?
                       view_coef : pln_ff[clip_idx];
   assign my_slice   = pkt_in.slice[cell_idx];

   // Pick operands: plane transform or corner dot product
   always_comb begin
      if (pkt_in.corner) begin
         a_op = {{(bfc_pkg::OPA_W - bfc_pkg::SLICE_W){my_slice[bfc_pkg::SLICE_W-1]}},
                 my_slice};
         b_op = (pkt_in.pos[cell_idx] == pkt_in.far) ? hi_ff : lo_ff;
      end else begin
         a_op = {plane_coef[bfc_pkg::COEF_W-1], plane_coef};
         b_op = mat_ff[pkt_in.row];
      end
   end

   assign prod = a_op * b_op;

   // Accumulate into the passing sum
   always_comb begin
      pkt_in_mod     = pkt_in;
      pkt_in_mod.sum = pkt_in.sum +
                       {{(bfc_pkg::SUM_W - bfc_pkg::PROD_W){prod[bfc_pkg::PROD_W-1]}}, prod};
   end

   // Hand the packet to the neighbor
   always_ff @(posedge clock) begin
      if (reset) begin
         pkt_ff <= '0;
      end else begin
         pkt_ff <= pkt_in_mod;
      end
   end

   assign pkt_out = pkt_ff;

endmodule

// ===== rtl/bfc_ctrl.sv =====
// Sequencer of the cull test: accepts transactions, feeds packets into the
// cell chain, collects plane equations and corner sums. Depends on bfc_pkg.
`timescale 1ns / 1ps

module bfc_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_func,
   input  logic [bfc_pkg::SLOT_W-1:0]  req_slot_index,
   input  logic                        csr_wr_en,
   input  logic [bfc_pkg::NUM_CLIP_PLANES-1:0] csr_wr_data,
   output bfc_pkg::we_type             we,
   output bfc_pkg::pkt_type            chain_in,
   input  bfc_pkg::pkt_type            chain_out,
   output logic                        rsp_valid,
   output logic [1:0]                  rsp_verdict
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_XF   = 3'b010,
      ST_CT   = 3'b100
   } state_type;

   state_type                               state_ff;
   logic [bfc_pkg::PLANE_W-1:0]             plane_ff;
   logic [2:0]                              iss_ff;
   logic [bfc_pkg::E_W-1:0]                 e_ff [bfc_pkg::NUM_CELLS];
   logic [bfc_pkg::SUM_W-1:0]               slo_ff;
   logic                                    inside_ff;
   logic                                    rej_ff;
   logic [bfc_pkg::NUM_CLIP_PLANES-1:0]     mask_ff;
   logic                                    rsp_valid_ff;
   logic [1:0]                              rsp_verdict_ff;

   logic                                    accept;
   logic                                    issuing;
   logic signed [bfc_pkg::TOT_W-1:0]        total;
   logic                                    below;
   logic [bfc_pkg::PLANE_W:0]               nxt;

   // Next active plane after cur: view planes always, clip planes by mask
   function automatic logic [bfc_pkg::PLANE_W:0] next_plane(
      input logic [bfc_pkg::PLANE_W-1:0]         cur,
      input logic [bfc_pkg::NUM_CLIP_PLANES-1:0] mask
   );
      logic                        found;
      logic [bfc_pkg::PLANE_W-1:0] idx;
      found = 1'b0;
      idx   = '0;
      for (int p = bfc_pkg::NUM_CLIP_PLANES - 1; p >= 0; p--) begin
         if (mask[p] && (bfc_pkg::PLANE_W'(p + bfc_pkg::VIEW_PLANES) > cur)) begin
            found = 1'b1;
            idx   = bfc_pkg::PLANE_W'(p + bfc_pkg::VIEW_PLANES);
         end
      end
      for (int n = bfc_pkg::VIEW_PLANES - 1; n >= 0; n--) begin
         if (bfc_pkg::PLANE_W'(n) > cur) begin
            found = 1'b1;
            idx   = bfc_pkg::PLANE_W'(n);
         end
      end
      return {found, idx};
   endfunction

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && (state_ff == ST_IDLE);
   assign issuing = (state_ff != ST_IDLE) && !iss_ff[2];

   // Decode store writes
   always_comb begin
      we.mat_we = accept && (req_func == bfc_pkg::FUNC_LOAD_ROW) &&
                  (req_slot_index < bfc_pkg::SLOT_W'(bfc_pkg::MAT_ROWS));
      we.pln_we = accept && (req_func == bfc_pkg::FUNC_LOAD_PLANE) &&
                  (req_slot_index < bfc_pkg::SLOT_W'(bfc_pkg::NUM_CLIP_PLANES));
      we.box_we = accept && (req_func == bfc_pkg::FUNC_TEST);
   end

   // Build the packet entering the chain
   always_comb begin
      chain_in          = '0;
      chain_in.valid    = issuing;
      chain_in.corner   = (state_ff == ST_CT);
      chain_in.row      = iss_ff[1:0];
      chain_in.plane    = plane_ff;
      chain_in.far      = ~iss_ff[1];
      chain_in.hi_slice = iss_ff[0];
      for (int i = 0; i < bfc_pkg::NUM_CELLS; i++) begin
         chain_in.pos[i] = ~e_ff[i][bfc_pkg::E_W-1] && (e_ff[i] != '0);
         if (iss_ff[0]) begin
            chain_in.slice[i] = {e_ff[i][bfc_pkg::E_W-1],
                                 e_ff[i][bfc_pkg::E_W-1:bfc_pkg::SLICE_SPLIT]};
         end else begin
            chain_in.slice[i] = {1'b0, e_ff[i][bfc_pkg::SLICE_SPLIT-1:0]};
         end
      end
      chain_in.sum = '0;
   end

   // Join the low and high slice sums; negative means the corner is outside
   assign total = $signed({{(bfc_pkg::TOT_W - bfc_pkg::SUM_W){slo_ff[bfc_pkg::SUM_W-1]}},
                           slo_ff}) +
                  ($signed({{(bfc_pkg::TOT_W - bfc_pkg::SUM_W)
                             {chain_out.sum[bfc_pkg::SUM_W-1]}}, chain_out.sum})
                   <<< bfc_pkg::SLICE_SPLIT);
   assign below = total[bfc_pkg::TOT_W-1];
   assign nxt   = next_plane(plane_ff, mask_ff);

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else if (csr_wr_en) begin
         mask_ff <= csr_wr_data;
      end
   end

   // Sequence the planes of one test
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         iss_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (issuing) begin
            iss_ff <= iss_ff + 3'd1;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && (req_func == bfc_pkg::FUNC_TEST)) begin
                  state_ff <= ST_XF;
                  iss_ff   <= '0;
               end
            end
            ST_XF: begin
               if (chain_out.valid && (chain_out.row == 2'd3)) begin
                  state_ff <= ST_CT;
                  iss_ff   <= '0;
               end
            end
            ST_CT: begin
               if (chain_out.valid && chain_out.hi_slice && !chain_out.far) begin
                  if (rej_ff || !nxt[bfc_pkg::PLANE_W]) begin
                     state_ff     <= ST_IDLE;
                     rsp_valid_ff <= 1'b1;
                  end else begin
                     state_ff <= ST_XF;
                     iss_ff   <= '0;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Collect plane equations, slice sums and test outcomes
   always_ff @(posedge clock) begin
      if (accept) begin
         plane_ff  <= '0;
         inside_ff <= 1'b1;
         rej_ff    <= 1'b0;
      end
      if ((state_ff == ST_XF) && chain_out.valid) begin
         e_ff[chain_out.row] <= chain_out.sum[bfc_pkg::E_W + bfc_pkg::FRAC_W - 1:
                                              bfc_pkg::FRAC_W];
      end
      if ((state_ff == ST_CT) && chain_out.valid) begin
         if (!chain_out.hi_slice) begin
            slo_ff <= chain_out.sum;
         end else if (chain_out.far) begin
            rej_ff <= below;
         end else begin
            if (below) begin
               inside_ff <= 1'b0;
            end
            if (rej_ff) begin
               rsp_verdict_ff <= bfc_pkg::VERDICT_REJECT;
            end else if (!nxt[bfc_pkg::PLANE_W]) begin
               rsp_verdict_ff <= (inside_ff && !below) ? bfc_pkg::VERDICT_INSIDE :
                                                         bfc_pkg::VERDICT_PARTIAL;
            end else begin
               plane_ff <= nxt[bfc_pkg::PLANE_W-1:0];
            end
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = rsp_verdict_ff;

endmodule

// ===== rtl/box_frustum_cull_test.sv =====
// Top level of the box frustum cull test: sequencer plus a chain of four
// multiply-accumulate cells. Depends on bfc_pkg, bfc_cell and bfc_ctrl.
`timescale 1ns / 1ps

// Classifies a Q16.16 model-space box against the six view planes of the
// loaded model-to-screen matrix and the clip planes enabled in the mask.
// A transaction is taken when start is high and busy is low. Loads give no
// result. A test gives one verdict, shown on
// rsp_verdict for exactly one cycle with rsp_valid; there is no way to hold
// it off, so the receiver must take it then. For each plane, four packets
// form the plane equation through the four-cell chain and four more form
// the far and near corner sums; each group of four waits for its last
// packet to leave the chain. A test runs the view planes, then the enabled
// clip planes, and ends early when a plane rejects the box.
module box_frustum_cull_test (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_func,
   input  logic [2:0]  req_slot_index,
   input  logic [31:0] req_coef_a,
   input  logic [31:0] req_coef_b,
   input  logic [31:0] req_coef_c,
   input  logic [31:0] req_coef_d,
   input  logic [31:0] req_box_min_x,
   input  logic [31:0] req_box_min_y,
   input  logic [31:0] req_box_min_z,
   input  logic [31:0] req_box_max_x,
   input  logic [31:0] req_box_max_y,
   input  logic [31:0] req_box_max_z,
   input  logic        csr_wr_en,
   input  logic [5:0]  csr_wr_data,
   output logic        rsp_valid,
   output logic [1:0]  rsp_verdict
);

   bfc_pkg::we_type            we;
   bfc_pkg::pkt_type           chain [bfc_pkg::NUM_CELLS + 1];
   bfc_pkg::wr_type            cell_wr [bfc_pkg::NUM_CELLS];
   logic [bfc_pkg::COEF_W-1:0] coefs [bfc_pkg::NUM_CELLS];
   logic [bfc_pkg::COEF_W-1:0] box_lo [bfc_pkg::NUM_CELLS];
   logic [bfc_pkg::COEF_W-1:0] box_hi [bfc_pkg::NUM_CELLS];

   bfc_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_slot_index (req_slot_index),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .we             (we),
      .chain_in       (chain[0]),
      .chain_out      (chain[bfc_pkg::NUM_CELLS]),
      .rsp_valid      (rsp_valid),
      .rsp_verdict    (rsp_verdict)
   );

   // Spread the request over the cells; the last cell scales the constant term
   always_comb begin
      coefs[0]  = req_coef_a;
      coefs[1]  = req_coef_b;
      coefs[2]  = req_coef_c;
      coefs[3]  = req_coef_d;
      box_lo[0] = req_box_min_x;
      box_lo[1] = req_box_min_y;
      box_lo[2] = req_box_min_z;
      box_lo[3] = bfc_pkg::ONE_Q;
      box_hi[0] = req_box_max_x;
      box_hi[1] = req_box_max_y;
      box_hi[2] = req_box_max_z;
      box_hi[3] = bfc_pkg::ONE_Q;
      for (int j = 0; j < bfc_pkg::NUM_CELLS; j++) begin
         cell_wr[j].mat_we = we.mat_we;
         cell_wr[j].pln_we = we.pln_we;
         cell_wr[j].box_we = we.box_we;
         cell_wr[j].slot   = req_slot_index;
         cell_wr[j].coef   = coefs[j];
         cell_wr[j].lo     = box_lo[j];
         cell_wr[j].hi     = box_hi[j];
      end
   end

   // Chain of cells
   for (genvar j = 0; j < bfc_pkg::NUM_CELLS; j++) begin : g_cell
      bfc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (2'(j)),
         .wr       (cell_wr[j]),
         .pkt_in   (chain[j]),
         .pkt_out  (chain[j+1])
      );
   end

endmodule

// ===== tb/bfc_verdict_checker.sv =====
// Verdict checker for the box frustum cull test: watches the request, CSR and
// response ports, keeps its own copy of the matrix, planes and mask, predicts
// each verdict. Depends on bfc_pkg.
`timescale 1ns / 1ps

module bfc_verdict_checker
   import bfc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_func,
   input  logic [2:0]  req_slot_index,
   input  logic [31:0] req_coef_a,
   input  logic [31:0] req_coef_b,
   input  logic [31:0] req_coef_c,
   input  logic [31:0] req_coef_d,
   input  logic [31:0] req_box_min_x,
   input  logic [31:0] req_box_min_y,
   input  logic [31:0] req_box_min_z,
   input  logic [31:0] req_box_max_x,
   input  logic [31:0] req_box_max_y,
   input  logic [31:0] req_box_max_z,
   input  logic        csr_wr_en,
   input  logic [5:0]  csr_wr_data,
   input  logic        rsp_valid,
   input  logic [1:0]  rsp_verdict,
   output int          fail_count,
   output int          pending,
   output int          verdict_seen [3]
);

   typedef logic signed [127:0] wide_t;

   wide_t      mat [16];
   wide_t      pln [NUM_CLIP_PLANES*4];
   logic [5:0] clip_mask;
   logic [1:0] verdict_q [$];
   wide_t      box_lo [3];
   wide_t      box_hi [3];

   initial begin
      fail_count = 0;
      verdict_seen = '{0, 0, 0};
      clip_mask = '0;
      foreach (mat[i]) mat[i] = '0;
      foreach (pln[i]) pln[i] = '0;
   end

   assign pending = verdict_q.size();

   // Test one plane against the held box: 2 when the far corner is below, 1
   // when only the near corner is, 0 otherwise.
   function automatic int plane_side(input wide_t e0, input wide_t e1, input wide_t e2,
                                     input wide_t e3);
      wide_t e [3];
      wide_t far_sum;
      wide_t near_sum;
      wide_t bound;
      e[0] = e0;
      e[1] = e1;
      e[2] = e2;
      far_sum = '0;
      near_sum = '0;
      for (int i = 0; i < 3; i++) begin
         far_sum  += e[i] * ((e[i] > 0) ? box_hi[i] : box_lo[i]);
         near_sum += e[i] * ((e[i] > 0) ? box_lo[i] : box_hi[i]);
      end
      bound = e3 * 65536;
      if (far_sum < bound) return 2;
      if (near_sum < bound) return 1;
      return 0;
   endfunction

   // Classify the held box against view planes, then enabled clip planes.
   function automatic logic [1:0] classify_box();
      wide_t e [4];
      wide_t acc;
      int    side;
      bit    in_view;
      in_view = 1;
      for (int k = 0; k < 6; k++) begin
         for (int i = 0; i < 4; i++)
            e[i] = (k % 2 == 0) ? mat[i*4+3] + mat[i*4+k/2] : mat[i*4+3] - mat[i*4+k/2];
         side = plane_side(e[0], e[1], e[2], -e[3]);
         if (side == 2) return VERDICT_REJECT;
         if (side == 1) in_view = 0;
      end
      for (int k = 0; k < NUM_CLIP_PLANES; k++) begin
         if (clip_mask[k]) begin
            for (int i = 0; i < 4; i++) begin
               acc = '0;
               for (int j = 0; j < 4; j++) acc += pln[k*4+j] * mat[i*4+j];
               e[i] = acc >>> 16;
            end
            side = plane_side(e[0], e[1], e[2], -e[3]);
            if (side == 2) return VERDICT_REJECT;
            if (side == 1) in_view = 0;
         end
      end
      return in_view ? VERDICT_INSIDE : VERDICT_PARTIAL;
   endfunction

   // Track config and requests, predict verdicts, compare responses
   always @(posedge clock) begin
      logic [1:0] want;
      if (reset) begin
         clip_mask <= '0;
         verdict_q.delete();
      end else begin
         if (csr_wr_en) clip_mask <= csr_wr_data;
         if (start && !busy) begin
            case (req_func)
               FUNC_LOAD_ROW: if (req_slot_index < MAT_ROWS) begin
                  mat[req_slot_index*4+0] = $signed(req_coef_a);
                  mat[req_slot_index*4+1] = $signed(req_coef_b);
                  mat[req_slot_index*4+2] = $signed(req_coef_c);
                  mat[req_slot_index*4+3] = $signed(req_coef_d);
               end
               FUNC_LOAD_PLANE: if (req_slot_index < NUM_CLIP_PLANES) begin
                  pln[req_slot_index*4+0] = $signed(req_coef_a);
                  pln[req_slot_index*4+1] = $signed(req_coef_b);
                  pln[req_slot_index*4+2] = $signed(req_coef_c);
                  pln[req_slot_index*4+3] = $signed(req_coef_d);
               end
               FUNC_TEST: begin
                  box_lo[0] = $signed(req_box_min_x);
                  box_lo[1] = $signed(req_box_min_y);
                  box_lo[2] = $signed(req_box_min_z);
                  box_hi[0] = $signed(req_box_max_x);
                  box_hi[1] = $signed(req_box_max_y);
                  box_hi[2] = $signed(req_box_max_z);
                  verdict_q.push_back(classify_box());
               end
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (verdict_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected verdict %0d", $realtime, rsp_verdict);
            end else begin
               want = verdict_q.pop_front();
               if (want <= 2) verdict_seen[want]++;
               if (rsp_verdict !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: verdict mismatch: expected %0d, actual %0d",
                              $realtime, want, rsp_verdict);
               end
            end
         end
      end
   end

endmodule

// ===== tb/tb.sv =====
// Testbench top for box_frustum_cull_test: clock, reset, stimulus, watchdog
// and verdict. Depends on bfc_pkg, box_frustum_cull_test, bfc_verdict_checker.
`timescale 1ns / 1ps

module tb;
   import bfc_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int         STALL_LIMIT = 5000;
   localparam int         SETTLE      = 24;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_func = '0;
   logic [2:0]  req_slot_index = '0;
   logic [31:0] req_coef_a = '0, req_coef_b = '0, req_coef_c = '0, req_coef_d = '0;
   logic [31:0] req_box_min_x = '0, req_box_min_y = '0, req_box_min_z = '0;
   logic [31:0] req_box_max_x = '0, req_box_max_y = '0, req_box_max_z = '0;
   logic        csr_wr_en = 1'b0;
   logic [5:0]  csr_wr_data = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_verdict;
   int          fail_count;
   int          pending;
   int          verdict_seen [3];
   int          idle_cycles = 0;
   int          tests_sent = 0;
   bit          gaps_on = 1;

   initial forever #4 clock = ~clock;

   box_frustum_cull_test u_dut (.*);

   bfc_verdict_checker u_checker (.*);

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   // Issue one transaction and hold it until accepted
   task automatic send(input logic [1:0] f, input logic [2:0] s,
                       input logic [31:0] a, input logic [31:0] b,
                       input logic [31:0] c, input logic [31:0] d,
                       input logic [31:0] lx, input logic [31:0] ly, input logic [31:0] lz,
                       input logic [31:0] hx, input logic [31:0] hy, input logic [31:0] hz);
      req_func <= f;
      req_slot_index <= s;
      req_coef_a <= a;
      req_coef_b <= b;
      req_coef_c <= c;
      req_coef_d <= d;
      req_box_min_x <= lx;
      req_box_min_y <= ly;
      req_box_min_z <= lz;
      req_box_max_x <= hx;
      req_box_max_y <= hy;
      req_box_max_z <= hz;
      start <= 1'b1;
      if (f == FUNC_TEST) tests_sent++;
      do @(posedge clock); while (busy);
      // random sender gap
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   task automatic load(input logic [1:0] f, input logic [2:0] s,
                       input logic [31:0] a, input logic [31:0] b,
                       input logic [31:0] c, input logic [31:0] d);
      send(f, s, a, b, c, d, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic test_box(input logic [31:0] lx, input logic [31:0] ly,
                           input logic [31:0] lz, input logic [31:0] hx,
                           input logic [31:0] hy, input logic [31:0] hz);
      send(FUNC_TEST, 3'($urandom), $urandom, $urandom, $urandom, $urandom,
           lx, ly, lz, hx, hy, hz);
   endtask

   // Drain all results, let the block settle, then write the mask
   task automatic set_mask(input logic [5:0] m);
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0 || busy) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Small signed Q16.16 value in +/- span units of 1/16
   function automatic logic [31:0] near(input int span);
      return 32'($signed($urandom_range(0, 2 * span * 4096)) - span * 4096);
   endfunction

   function automatic logic [31:0] coef_val(input bit diag);
      if ($urandom_range(0, 19) == 0) return $urandom;
      return (diag ? 32'sd65536 : 32'sd0) + near(2);
   endfunction

   task automatic random_test();
      logic [31:0] lo [3];
      logic [31:0] hi [3];
      for (int i = 0; i < 3; i++) begin
         case ($urandom_range(0, 9))
            0: begin lo[i] = $urandom; hi[i] = $urandom; end
            1: begin hi[i] = near(32); lo[i] = hi[i] + near(8); end
            default: begin lo[i] = near(40); hi[i] = lo[i] + 32'($urandom_range(0, 3 * 65536)); end
         endcase
      end
      test_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
   endtask

   task automatic random_item();
      int          pick;
      logic [2:0]  s;
      pick = $urandom_range(0, 99);
      if (pick < 70) random_test();
      else if (pick < 85) begin
         s = 3'($urandom_range(0, MAT_ROWS - 1));
         load(FUNC_LOAD_ROW, s, coef_val(s == 0), coef_val(s == 1),
              coef_val(s == 2), coef_val(s == 3));
      end else if (pick < 95)
         load(FUNC_LOAD_PLANE, 3'($urandom_range(0, NUM_CLIP_PLANES - 1)),
              near(16), near(16), near(16), near(32));
      else begin
         // drop: unused code or a slot out of range
         case ($urandom_range(0, 2))
            0: load(FUNC_UNUSED, 3'($urandom), $urandom, $urandom, $urandom, $urandom);
            1: load(FUNC_LOAD_ROW, 3'($urandom_range(MAT_ROWS, 7)),
                    $urandom, $urandom, $urandom, $urandom);
            default: load(FUNC_LOAD_PLANE, 3'($urandom_range(NUM_CLIP_PLANES, 7)),
                          $urandom, $urandom, $urandom, $urandom);
         endcase
      end
   endtask

   initial begin
      logic [5:0] masks [9];
      masks = '{6'h3f, 6'h00, 6'h15, 6'h2a, 6'h01, 6'h20, 6'h3f, 6'h00, 6'h3f};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: identity matrix, every clip plane, then corner cases
      for (int r = 0; r < MAT_ROWS; r++)
         load(FUNC_LOAD_ROW, 3'(r), r == 0 ? ONE_Q : 0, r == 1 ? ONE_Q : 0,
              r == 2 ? ONE_Q : 0, r == 3 ? ONE_Q : 0);
      for (int p = 0; p < NUM_CLIP_PLANES; p++)
         load(FUNC_LOAD_PLANE, 3'(p), p == 0 ? ONE_Q : 0, p == 1 ? ONE_Q : 0,
              p == 2 ? -ONE_Q : 0, -(2 * ONE_Q));
      test_box(-32'sd32768, -32'sd32768, -32'sd32768, 32'sd32768, 32'sd32768, 32'sd32768);
      test_box(-32'sd131072, 0, 0, 32'sd131072, 1, 1);
      test_box(32'sd196608, 0, 0, 32'sd262144, 1, 1);
      test_box(32'h80000000, 32'h80000000, 32'h80000000,
               32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
      test_box(32'sd65536, 32'sd65536, 32'sd65536, -32'sd65536, -32'sd65536, -32'sd65536);
      load(FUNC_UNUSED, 3'd0, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
      load(FUNC_LOAD_ROW, 3'd7, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
      load(FUNC_LOAD_PLANE, 3'd6, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
      test_box(0, 0, 0, 0, 0, 0);
      set_mask(6'h3f);
      test_box(0, 0, 0, 0, 0, 0);
      test_box(-32'sd32768, -32'sd32768, -32'sd32768, 32'sd32768, 32'sd32768, 32'sd32768);
      for (int r = 0; r < MAT_ROWS; r++)
         load(FUNC_LOAD_ROW, 3'(r), 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
      test_box(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);

      // Random phases, each behind a mask change; no gaps in the last one
      for (int ph = 0; ph < 9; ph++) begin
         set_mask(ph == 2 ? 6'($urandom) : masks[ph]);
         for (int r = 0; r < MAT_ROWS; r++)
            load(FUNC_LOAD_ROW, 3'(r), coef_val(r == 0), coef_val(r == 1),
                 coef_val(r == 2), coef_val(r == 3));
         gaps_on = (ph != 8);
         for (int n = 0; n < 150; n++) random_item();
      end

      // Wind down
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (250) @(posedge clock);
      $display("Sent %0d box tests over 10 mask settings with matrix and plane reloads.",
               tests_sent);
      $display("Verdicts seen: inside %0d, partial %0d, rejected %0d.",
               verdict_seen[0], verdict_seen[1], verdict_seen[2]);
      if (fail_count == 0) $display("tb passed");
      else $display("tb failed");
      $finish;
   end

endmodule

// ===== box_frustum_cull_test.f =====
rtl/bfc_pkg.sv
rtl/bfc_cell.sv
rtl/bfc_ctrl.sv
rtl/box_frustum_cull_test.sv
tb/bfc_verdict_checker.sv
tb/tb.sv
